>>> design/cbc_pkg.sv
// cbc_pkg: shared types, constants and the cordic angle table for the compass bearing block
// no dependencies

package cbc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_TABLE_LEN  = 24;
    localparam int CFG_DATA_W       = 24;
    localparam int CFG_IDX_W        = 3;

    localparam logic [31:0] ATAN_TURNS [0:ANGLE_TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic [15:0] FULL_TURN_CDEG = 16'd36000;
    localparam logic signed [15:0] DECL_MAX = 16'sd18000;
    localparam logic signed [15:0] DECL_MIN = -16'sd18000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_XX     = 3'd0,
        CFG_GAIN_XY     = 3'd1,
        CFG_OFFSET_X    = 3'd2,
        CFG_GAIN_YX     = 3'd3,
        CFG_GAIN_YY     = 3'd4,
        CFG_OFFSET_Y    = 3'd5,
        CFG_DECLINATION = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_RAW        = 1'b0,
        OP_CALIBRATED = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
    } t_cbc_in;

    typedef struct packed {
        logic [15:0]        bearing;
        logic signed [23:0] field_x;
        logic signed [23:0] field_y;
        logic               zero_field;
    } t_cbc_out;

endpackage

>>> design/compass_bearing_calibrated_top.sv
// compass_bearing_calibrated_top: pipelined magnetometer bearing with affine correction,
// unrolled cordic vectoring and declination; depends on cbc_pkg
//
//  port group      dir   width            meaning
//  i_valid/o_ready in    t_cbc_in (33)    sample beat: opcode, raw_x, raw_y
//  o_valid/i_ready out   t_cbc_out (65)   result beat: bearing, field_x, field_y, zero_field
//  i_cfg_*         in    3 + 24           register write, no wait, no read-back
//
// one beat in per cycle while the output is not stalled
// the cordic chain has one register per step, at most ANGLE_TABLE_LEN steps
// i_rst_n clears the valid bits and loads the register reset values
// a stall on the output holds every stage at once; nothing is lost or repeated

module compass_bearing_calibrated_top
    import cbc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_cbc_in               i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_cbc_out              o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int STEPS = (CORDIC_STEPS < ANGLE_TABLE_LEN) ? CORDIC_STEPS : ANGLE_TABLE_LEN;
    localparam int CW    = 44;
    localparam int NV    = STEPS + 5;

    // configuration registers
    logic signed [15:0] r_gain_xx, r_gain_xy, r_gain_yx, r_gain_yy, r_decl;
    logic signed [23:0] r_off_x, r_off_y;
    logic signed [15:0] n_decl;

    always_comb begin
        n_decl = i_cfg_data[15:0];
        if (n_decl > DECL_MAX) begin
            n_decl = DECL_MAX;
        end else if (n_decl < DECL_MIN) begin
            n_decl = DECL_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_xx <= 16'sd4096;
            r_gain_xy <= '0;
            r_off_x   <= '0;
            r_gain_yx <= '0;
            r_gain_yy <= 16'sd4096;
            r_off_y   <= '0;
            r_decl    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_XX:     r_gain_xx <= i_cfg_data[15:0];
                CFG_GAIN_XY:     r_gain_xy <= i_cfg_data[15:0];
                CFG_OFFSET_X:    r_off_x   <= i_cfg_data;
                CFG_GAIN_YX:     r_gain_yx <= i_cfg_data[15:0];
                CFG_GAIN_YY:     r_gain_yy <= i_cfg_data[15:0];
                CFG_OFFSET_Y:    r_off_y   <= i_cfg_data;
                CFG_DECLINATION: r_decl    <= n_decl;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic          en;
    logic [NV-1:0] r_vld;

    assign en      = !r_vld[NV-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // stage 1: products
    logic signed [31:0] r_p_xx, r_p_xy, r_p_yx, r_p_yy;
    logic signed [15:0] r1_rx, r1_ry;
    logic               r1_op, r1_apply;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_xx   <= 32'(i_data.raw_x) * 32'(r_gain_xx);
            r_p_xy   <= 32'(i_data.raw_y) * 32'(r_gain_xy);
            r_p_yx   <= 32'(i_data.raw_x) * 32'(r_gain_yx);
            r_p_yy   <= 32'(i_data.raw_y) * 32'(r_gain_yy);
            r1_rx    <= i_data.raw_x;
            r1_ry    <= i_data.raw_y;
            r1_op    <= i_data.opcode;
            r1_apply <= (i_data.opcode == OP_CALIBRATED) && (i_data.raw_x != '0)
                        && (i_data.raw_y != '0);
        end
    end

    // stage 2: round, offset, saturate if calibrated and raw_x, raw_y nonzero; else raw << 4
    function automatic logic signed [23:0] corr(input logic signed [31:0] pa,
                                                input logic signed [31:0] pb,
                                                input logic signed [23:0] off);
        logic signed [33:0] acc;
        logic signed [25:0] sh;
        logic signed [26:0] sum;
        acc = 34'(pa) + 34'(pb) + 34'sd128;
        sh  = 26'(acc >>> 8);
        sum = 27'(sh) + 27'(off);
        if (sum > 27'sd8388607) begin
            return 24'sh7fffff;
        end else if (sum < -27'sd8388608) begin
            return 24'sh800000;
        end
        return sum[23:0];
    endfunction

    logic signed [23:0] r2_fx, r2_fy;
    logic               r2_op;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op <= r1_op;
            if (r1_apply) begin
                r2_fx <= corr(r_p_xx, r_p_xy, r_off_x);
                r2_fy <= corr(r_p_yx, r_p_yy, r_off_y);
            end else begin
                r2_fx <= {{4{r1_rx[15]}}, r1_rx, 4'b0};
                r2_fy <= {{4{r1_ry[15]}}, r1_ry, 4'b0};
            end
        end
    end

    // stage 3 and cordic chain; index 0 is the half-turn pre-rotation
    logic signed [CW-1:0] r_cx [0:STEPS];
    logic signed [CW-1:0] r_cy [0:STEPS];
    logic [31:0]          r_cz [0:STEPS];
    logic signed [23:0]   r_fx [0:STEPS];
    logic signed [23:0]   r_fy [0:STEPS];
    logic                 r_op [0:STEPS];
    logic                 r_zr [0:STEPS];
    logic signed [CW-1:0] x0, y0;

    assign x0 = {{(CW-40){r2_fx[23]}}, r2_fx, 16'b0};
    assign y0 = {{(CW-40){r2_fy[23]}}, r2_fy, 16'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx[0] <= r2_fx;
            r_fy[0] <= r2_fy;
            r_op[0] <= r2_op;
            r_zr[0] <= (r2_fx == '0) && (r2_fy == '0);
            if (r2_fx[23]) begin
                r_cx[0] <= -x0;
                r_cy[0] <= -y0;
                r_cz[0] <= 32'h8000_0000;
            end else begin
                r_cx[0] <= x0;
                r_cy[0] <= y0;
                r_cz[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_fx[k+1] <= r_fx[k];
                r_fy[k+1] <= r_fy[k];
                r_op[k+1] <= r_op[k];
                r_zr[k+1] <= r_zr[k];
                if (!r_cy[k][CW-1]) begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] + ATAN_TURNS[k];
                end else begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] - ATAN_TURNS[k];
                end
            end
        end
    end

    // turns to centidegrees
    logic [47:0]        prod;
    logic [15:0]        r_cdeg;
    logic signed [23:0] rm_fx, rm_fy;
    logic               rm_op, rm_zr;

    assign prod = {16'b0, r_cz[STEPS]} * {32'b0, FULL_TURN_CDEG} + 48'h0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cdeg <= prod[47:32];
            rm_fx  <= r_fx[STEPS];
            rm_fy  <= r_fy[STEPS];
            rm_op  <= r_op[STEPS];
            rm_zr  <= r_zr[STEPS];
        end
    end

    // declination and wrap, for calibrated beats only; a zero field gives bearing 0
    logic [15:0]        base;
    logic signed [17:0] bsum;
    logic [15:0]        n_bearing;

    always_comb begin
        base = (r_cdeg >= FULL_TURN_CDEG) ? '0 : r_cdeg;
        bsum = $signed({2'b0, base}) + 18'(r_decl);
        if (rm_zr) begin
            n_bearing = '0;
        end else if (rm_op == OP_CALIBRATED) begin
            if (bsum < 0) begin
                bsum = bsum + $signed({2'b0, FULL_TURN_CDEG});
            end else if (bsum >= $signed({2'b0, FULL_TURN_CDEG})) begin
                bsum = bsum - $signed({2'b0, FULL_TURN_CDEG});
            end
            n_bearing = bsum[15:0];
        end else begin
            n_bearing = base;
        end
    end

    t_cbc_out r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.bearing    <= n_bearing;
            r_out.field_x    <= rm_fx;
            r_out.field_y    <= rm_fy;
            r_out.zero_field <= rm_zr;
        end
    end

    assign o_data = r_out;

endmodule
